@@ design/bfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the binary frame receiver
// Register map, reset values, receive phases and the result beat layout.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// Payload store size in bytes (2 .. 65536); the index wraps here
	localparam int BFR_PAYLOAD_BYTES = 512;
	localparam int BFR_IDX_W         = (BFR_PAYLOAD_BYTES > 2) ? $clog2(BFR_PAYLOAD_BYTES) : 1;

	localparam int BFR_NUM_REGS = 8;
	localparam int BFR_REG_W    = 16;
	localparam int BFR_RIDX_W   = 3;
	localparam int BFR_CNT_W    = 17;
	localparam int BFR_PIDX_W   = 9;
	localparam int BFR_CLASS_W  = 3;

	localparam logic [BFR_RIDX_W-1:0] BFR_REG_SYNC = 3'd0;

	typedef logic [BFR_NUM_REGS-1:0][BFR_REG_W-1:0] bfr_regs_t;

	// Entry 7 first in the packed literal
	localparam bfr_regs_t BFR_REG_RESET = {
		16'd2200, 16'd3006, 16'd3003, 16'd3002,
		16'd3011, 16'd3001, 16'd3000, 16'h81FF
	};

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_ID1     = 4'd2,
		PH_ID2     = 4'd3,
		PH_LEN1    = 4'd4,
		PH_LEN2    = 4'd5,
		PH_RES1    = 4'd6,
		PH_RES2    = 4'd7,
		PH_CK1     = 4'd8,
		PH_CK2     = 4'd9,
		PH_PAYLOAD = 4'd10,
		PH_TAIL    = 4'd11
	} bfr_phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_FRAME   = 1'b1
	} bfr_kind_t;

	typedef struct packed {
		bfr_kind_t              kind;
		logic [7:0]             data;
		logic [BFR_PIDX_W-1:0]  index;
		logic [BFR_REG_W-1:0]   id;
		logic [BFR_REG_W-1:0]   words;
		logic                   ok;
		logic [BFR_CLASS_W-1:0] cls;
	} bfr_result_t;

endpackage

@@ design/bfr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_core: frame parser state machine
// Steps the receive phase for one byte, captures the header words, counts
// payload bytes and builds the payload or frame-finished result beat.
// ----------------------------------------------------------------------------
module bfr_core
	import bfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  bfr_regs_t   regs,
	output logic        has_result,
	output bfr_result_t result
);

	bfr_phase_t             phase_q, phase_d;
	logic [BFR_REG_W-1:0]   id_q, words_q, rsv_q, ck_q;
	logic [BFR_CNT_W-1:0]   count_q;
	logic [BFR_IDX_W-1:0]   idx_q;
	logic                   more_payload;
	logic [BFR_REG_W-1:0]   hdr_sum;
	logic                   hdr_ok;
	logic [BFR_CLASS_W-1:0] id_cls;
	logic [BFR_REG_W-1:0]   sync_word;

	assign sync_word    = regs[BFR_REG_SYNC];
	assign more_payload = count_q < {words_q, 1'b0};
	// checksum is the negated sum, so sum plus checksum wraps to zero
	assign hdr_sum      = sync_word + id_q + words_q + rsv_q;
	assign hdr_ok       = (hdr_sum + ck_q) == '0;

	// lowest-numbered matching id register wins
	always_comb begin
		id_cls = '0;
		for (int k = BFR_NUM_REGS - 1; k >= 1; k--) begin
			if (regs[k] == id_q) begin
				id_cls = BFR_CLASS_W'(k);
			end
		end
	end

	always_comb begin
		case (phase_q)
			PH_SYNC1:   phase_d = (rx_byte == sync_word[7:0]) ? PH_SYNC2 : PH_SYNC1;
			PH_SYNC2:   phase_d = (rx_byte == sync_word[15:8]) ? PH_ID1 : PH_SYNC1;
			PH_ID1:     phase_d = PH_ID2;
			PH_ID2:     phase_d = PH_LEN1;
			PH_LEN1:    phase_d = PH_LEN2;
			PH_LEN2:    phase_d = PH_RES1;
			PH_RES1:    phase_d = PH_RES2;
			PH_RES2:    phase_d = PH_CK1;
			PH_CK1:     phase_d = PH_CK2;
			PH_CK2:     phase_d = PH_PAYLOAD;
			PH_PAYLOAD: phase_d = more_payload ? PH_PAYLOAD : PH_TAIL;
			PH_TAIL:    phase_d = PH_SYNC1;
			default:    phase_d = (rx_byte == sync_word[7:0]) ? PH_SYNC2 : PH_SYNC1;
		endcase
	end

	always_comb begin
		has_result   = 1'b0;
		result       = '0;
		result.kind  = KIND_PAYLOAD;
		result.id    = id_q;
		result.words = words_q;
		case (phase_q)
			PH_PAYLOAD: begin
				has_result   = more_payload;
				result.data  = rx_byte;
				result.index = BFR_PIDX_W'(idx_q);
			end
			PH_TAIL: begin
				has_result  = 1'b1;
				result.kind = KIND_FRAME;
				result.ok   = hdr_ok;
				result.cls  = hdr_ok ? id_cls : '0;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			id_q    <= '0;
			words_q <= '0;
			rsv_q   <= '0;
			ck_q    <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_ID1:  id_q[7:0]     <= rx_byte;
				PH_ID2:  id_q[15:8]    <= rx_byte;
				PH_LEN1: words_q[7:0]  <= rx_byte;
				PH_LEN2: begin
					words_q[15:8] <= rx_byte;
					count_q       <= '0;
					idx_q         <= '0;
				end
				PH_RES1: rsv_q[7:0]    <= rx_byte;
				PH_RES2: rsv_q[15:8]   <= rx_byte;
				PH_CK1:  ck_q[7:0]     <= rx_byte;
				PH_CK2:  ck_q[15:8]    <= rx_byte;
				PH_PAYLOAD: begin
					if (more_payload) begin
						count_q <= count_q + 1'b1;
						// wrap the store index at the buffer size
						if (idx_q == BFR_IDX_W'(BFR_PAYLOAD_BYTES - 1)) begin
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						count_q <= '0;
						idx_q   <= '0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

@@ design/binary_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_frame_receiver: sync-word frame parser with header checksum
// Input register, parser step, result register; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and sustains one byte per clock unless a
// result stalls. A byte waits in the input register, is parsed there by a
// single state step, and its result (if any) lands in the result register,
// from which it is offered. A byte that makes no result passes even while
// the result register is stalled; only a byte that makes a result waits
// for the result register to drain. Each payload byte comes out with its
// wrapping store index; the second trailing byte after the payload yields
// the frame beat with the header check and id class.
// Configuration registers may only be written while the block is idle.
// ----------------------------------------------------------------------------
module binary_frame_receiver
	import bfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [BFR_RIDX_W-1:0]  cfg_index,
	input  logic [BFR_REG_W-1:0]   cfg_data,
	input  logic                   rx_valid,
	output logic                   rx_ready,
	input  logic [7:0]             rx_byte,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic                   result_kind,
	output logic [7:0]             payload_byte,
	output logic [BFR_PIDX_W-1:0]  payload_index,
	output logic [BFR_REG_W-1:0]   frame_id,
	output logic [BFR_REG_W-1:0]   frame_words,
	output logic                   header_ok,
	output logic [BFR_CLASS_W-1:0] frame_class
);

	bfr_regs_t   regs_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        has_result;
	bfr_result_t result;
	logic        step;
	logic        res_free;
	bfr_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= BFR_REG_RESET;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	assign res_free = !res_valid || res_ready;
	// advance the parsed byte unless its result has nowhere to go
	assign step     = valid_s1 && (!has_result || res_free);
	assign rx_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	bfr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.regs       (regs_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_free) begin
			res_valid <= step && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && step && has_result) begin
			res_q <= result;
		end
	end

	assign result_kind   = res_q.kind;
	assign payload_byte  = res_q.data;
	assign payload_index = res_q.index;
	assign frame_id      = res_q.id;
	assign frame_words   = res_q.words;
	assign header_ok     = res_q.ok;
	assign frame_class   = res_q.cls;

endmodule

@@ design/bfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_checker: port-level checks for the binary frame receiver
// Watches the result channel and the field combinations it may show.
// ----------------------------------------------------------------------------
module bfr_checker
	import bfr_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   rx_valid,
	input logic                   rx_ready,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic                   result_kind,
	input logic [BFR_PIDX_W-1:0]  payload_index,
	input logic                   header_ok,
	input logic [BFR_CLASS_W-1:0] frame_class
);

	// a stalled result beat stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// a class is only reported for a frame whose header checked out
	a_class_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind && frame_class != '0 |-> header_ok)
		else $error("id class reported on checksum error");

	// payload beats carry no frame status
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !result_kind |-> !header_ok && frame_class == '0)
		else $error("frame status on payload beat");

	// store index stays inside the buffer
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !result_kind |->
			(BFR_PAYLOAD_BYTES >= (1 << BFR_PIDX_W)) ||
			(int'(payload_index) < BFR_PAYLOAD_BYTES))
		else $error("payload index beyond buffer size");

	// no beat out of nothing: a result beat needs a byte taken or a beat already up
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(rx_valid && rx_ready) && !$past(res_valid, 1) && !$past(rx_valid && rx_ready, 2)
			&& $past(arst_n, 2) |-> !res_valid)
		else $error("result beat without a byte taken");

endmodule

bind binary_frame_receiver bfr_checker u_bfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx_valid),
	.rx_ready      (rx_ready),
	.res_valid     (res_valid),
	.res_ready     (res_ready),
	.result_kind   (result_kind),
	.payload_index (payload_index),
	.header_ok     (header_ok),
	.frame_class   (frame_class)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the binary frame receiver
// A driver feeds received bytes from a queue. Each byte it hands over is run
// through a local copy of the parser, which records the payload and frame
// beats that byte should produce. A monitor pops those at the result port and
// compares them field by field. Register settings change only once the block
// has gone quiet, once even between the id and the length of a frame.
// ----------------------------------------------------------------------------
module tb;
	import bfr_pkg::*;

	localparam int LONG_HOLD     = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 2000;

	localparam logic [BFR_RIDX_W-1:0] REG_CLASS1 = 3'd1;
	localparam logic [BFR_RIDX_W-1:0] REG_CLASS2 = 3'd2;
	localparam logic [BFR_RIDX_W-1:0] REG_CLASS7 = 3'd7;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [BFR_RIDX_W-1:0]  cfg_index = '0;
	logic [BFR_REG_W-1:0]   cfg_data  = '0;
	logic                   rx_valid  = 1'b0;
	logic                   rx_ready;
	logic [7:0]             rx_byte   = '0;
	logic                   res_valid;
	logic                   res_ready = 1'b0;
	logic                   result_kind;
	logic [7:0]             payload_byte;
	logic [BFR_PIDX_W-1:0]  payload_index;
	logic [BFR_REG_W-1:0]   frame_id;
	logic [BFR_REG_W-1:0]   frame_words;
	logic                   header_ok;
	logic [BFR_CLASS_W-1:0] frame_class;

	binary_frame_receiver u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.frame_id     (frame_id),
		.frame_words  (frame_words),
		.header_ok    (header_ok),
		.frame_class  (frame_class)
	);

	always #5 clk = ~clk;

	wire in_beat  = rx_valid && rx_ready;
	wire out_beat = res_valid && res_ready;

	// register copy and parser state of the local frame decoder
	logic [BFR_REG_W-1:0] cfg_shadow [BFR_NUM_REGS];
	bfr_phase_t           model_phase  = PH_SYNC1;
	logic [15:0]          held_id      = '0;
	logic [15:0]          held_words   = '0;
	logic [15:0]          held_res     = '0;
	logic [15:0]          held_ck      = '0;
	logic [BFR_CNT_W-1:0] byte_count   = '0;

	logic [7:0]  bytes_to_send [$];
	bfr_result_t beats_due [$];
	bfr_result_t due;

	int errors        = 0;
	int items_pushed  = 0;
	int settings_used = 1;
	int frames_seen   = 0;
	int frames_ok     = 0;
	int frames_known  = 0;
	int payload_seen  = 0;
	int send_gap      = 0;
	int recv_stall    = 0;
	int hold_asks     = 0;
	int hold_taken    = 0;
	int quiet         = 0;
	bit no_idle       = 1'b0;

	int          mid_class;
	logic [15:0] mid_id;
	logic [15:0] mid_res;
	logic [15:0] shared_id;

	// Advance the local parser by one byte and queue any beat it yields.
	task automatic parse_byte(input logic [7:0] b);
		bfr_result_t r;
		logic [15:0] sum;
		r       = '0;
		r.kind  = KIND_PAYLOAD;
		r.id    = held_id;
		r.words = held_words;
		case (model_phase)
			PH_SYNC2: begin
				model_phase = (b == cfg_shadow[BFR_REG_SYNC][15:8]) ? PH_ID1 : PH_SYNC1;
			end
			PH_ID1: begin held_id[7:0] = b; model_phase = PH_ID2; end
			PH_ID2: begin held_id[15:8] = b; model_phase = PH_LEN1; end
			PH_LEN1: begin held_words[7:0] = b; model_phase = PH_LEN2; end
			PH_LEN2: begin
				held_words[15:8] = b;
				byte_count = '0;
				model_phase = PH_RES1;
			end
			PH_RES1: begin held_res[7:0] = b; model_phase = PH_RES2; end
			PH_RES2: begin held_res[15:8] = b; model_phase = PH_CK1; end
			PH_CK1: begin held_ck[7:0] = b; model_phase = PH_CK2; end
			PH_CK2: begin held_ck[15:8] = b; model_phase = PH_PAYLOAD; end
			PH_PAYLOAD: begin
				if (byte_count < {held_words, 1'b0}) begin
					r.data  = b;
					r.index = BFR_PIDX_W'(byte_count % BFR_PAYLOAD_BYTES);
					byte_count = byte_count + 1'b1;
					beats_due.push_back(r);
				end else begin
					// first trailing byte
					byte_count = '0;
					model_phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				sum    = cfg_shadow[BFR_REG_SYNC] + held_id + held_words + held_res;
				r.kind = KIND_FRAME;
				r.ok   = (16'(16'h0 - sum) == held_ck);
				if (r.ok) begin
					// lowest matching register wins
					for (int k = BFR_NUM_REGS - 1; k >= 1; k--) begin
						if (cfg_shadow[k] == held_id)
							r.cls = BFR_CLASS_W'(k);
					end
				end
				model_phase = PH_SYNC1;
				beats_due.push_back(r);
			end
			default: begin
				model_phase = (b == cfg_shadow[BFR_REG_SYNC][7:0]) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_beat)
				parse_byte(rx_byte);
			if (!rx_valid || rx_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					rx_valid <= 1'b0;
				end else if (bytes_to_send.size() == 0) begin
					rx_valid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 19) == 0) begin
					send_gap <= $urandom_range(0, 14);
					rx_valid <= 1'b0;
				end else begin
					rx_valid <= 1'b1;
					rx_byte  <= bytes_to_send.pop_front();
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_beat) begin
				if (beats_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none, actual kind %0d",
						$time, result_kind);
					errors++;
				end else begin
					due = beats_due.pop_front();
					check_field("result_kind", due.kind, result_kind);
					check_field("payload_byte", due.data, payload_byte);
					check_field("payload_index", due.index, payload_index);
					check_field("frame_id", due.id, frame_id);
					check_field("frame_words", due.words, frame_words);
					check_field("header_ok", due.ok, header_ok);
					check_field("frame_class", due.cls, frame_class);
					if (due.kind == KIND_FRAME) begin
						frames_seen++;
						if (due.ok)
							frames_ok++;
						if (due.cls != 0)
							frames_known++;
					end else begin
						payload_seen++;
					end
				end
			end
			if (hold_taken != hold_asks) begin
				hold_taken <= hold_asks;
				recv_stall <= LONG_HOLD;
				res_ready  <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				res_ready  <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				recv_stall <= $urandom_range(0, 14);
				res_ready  <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || in_beat || out_beat || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		bytes_to_send.push_back(b);
		items_pushed++;
	endtask

	task automatic push_word(input logic [15:0] w);
		push_byte(w[7:0]);
		push_byte(w[15:8]);
	endtask

	// length, reserved word, checksum, payload and the two trailing bytes
	task automatic push_body(input logic [15:0] words, input logic [15:0] res,
		input logic [15:0] ck, input int fill);
		push_word(words);
		push_word(res);
		push_word(ck);
		for (int n = 0; n < 2 * words; n++)
			push_byte(fill < 0 ? 8'($urandom) : (n[0] ? ~8'(fill) : 8'(fill)));
		push_byte(8'($urandom));
		push_byte(8'($urandom));
	endtask

	task automatic push_frame(input logic [15:0] id, input logic [15:0] words,
		input logic [15:0] res, input bit good, input int fill);
		logic [15:0] ck;
		ck = 16'h0 - (cfg_shadow[BFR_REG_SYNC] + id + words + res);
		if (!good)
			ck = ck ^ (16'h1 << $urandom_range(0, 15));
		push_word(cfg_shadow[BFR_REG_SYNC]);
		push_word(id);
		push_body(words, res, ck, fill);
	endtask

	function automatic logic [7:0] off_sync_hi();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == cfg_shadow[BFR_REG_SYNC][15:8])
			b = b + 8'd1;
		return b;
	endfunction

	function automatic logic [15:0] pick_id();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: return cfg_shadow[$urandom_range(1, BFR_NUM_REGS - 1)];
		endcase
	endfunction

	// Line noise and false sync starts now and then, then a frame with random content.
	task automatic push_traffic_frame(input int max_words);
		logic [7:0]  b;
		logic [15:0] words;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom);
				push_byte(b);
				// never leave the hunt half way into a sync word
				if (b == cfg_shadow[BFR_REG_SYNC][7:0])
					push_byte(off_sync_hi());
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			push_byte(cfg_shadow[BFR_REG_SYNC][7:0]);
			push_byte(off_sync_hi());
		end
		if ($urandom_range(0, 3) == 0)
			words = 16'($urandom_range(4, max_words));
		else
			words = 16'($urandom_range(0, 3));
		push_frame(pick_id(), words, 16'($urandom), $urandom_range(0, 4) != 0, -1);
	endtask

	// Wait until every byte is taken and every beat is back, then let the
	// input register empty out.
	task automatic settle();
		@(negedge clk);
		while (bytes_to_send.size() != 0 || rx_valid || beats_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [BFR_RIDX_W-1:0] idx, input logic [BFR_REG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_shadow[idx] = val;
		@(negedge clk);
	endtask

	task automatic send_phase(input int quota, input int max_words);
		int start;
		start = items_pushed;
		while (items_pushed - start < quota)
			push_traffic_frame(max_words);
		settle();
		settings_used++;
	endtask

	initial begin
		for (int k = 0; k < BFR_NUM_REGS; k++)
			cfg_shadow[k] = BFR_REG_RESET[k];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: shortest frame, a sync start whose wrong second
		// byte is itself the first sync byte, then a frame of 00/FF payload
		push_frame(cfg_shadow[REG_CLASS1], 16'd0, 16'd0, 1'b1, -1);
		push_byte(cfg_shadow[BFR_REG_SYNC][7:0]);
		push_byte(cfg_shadow[BFR_REG_SYNC][7:0]);
		push_byte(cfg_shadow[BFR_REG_SYNC][15:8]);
		push_frame(cfg_shadow[REG_CLASS7], 16'd1, 16'hFFFF, 1'b1, 8'h00);
		settle();

		// all-zero sync word, zero and all-ones ids
		write_reg(BFR_REG_SYNC, 16'h0000);
		write_reg(REG_CLASS1, 16'h0000);
		write_reg(REG_CLASS2, 16'hFFFF);
		for (int k = REG_CLASS2 + 1; k < BFR_NUM_REGS; k++)
			write_reg(BFR_RIDX_W'(k), 16'($urandom));
		send_phase(80, 12);

		// all-ones sync word, one id shared by classes 2 to 7
		write_reg(BFR_REG_SYNC, 16'hFFFF);
		write_reg(REG_CLASS1, 16'($urandom));
		shared_id = 16'($urandom);
		for (int k = REG_CLASS2; k < BFR_NUM_REGS; k++)
			write_reg(BFR_RIDX_W'(k), shared_id);
		send_phase(80, 12);

		// random registers; the receiver holds off long enough to back up input
		for (int k = 0; k < BFR_NUM_REGS; k++)
			write_reg(BFR_RIDX_W'(k), 16'($urandom));
		hold_asks++;
		send_phase(100, 12);

		// change sync word and one id between the id and the length of a frame
		mid_id    = 16'($urandom);
		mid_class = $urandom_range(1, BFR_NUM_REGS - 1);
		push_word(cfg_shadow[BFR_REG_SYNC]);
		push_word(mid_id);
		settle();
		write_reg(BFR_REG_SYNC, 16'($urandom));
		write_reg(BFR_RIDX_W'(mid_class), mid_id);
		mid_res = 16'($urandom);
		push_body(16'd1, mid_res,
			16'h0 - (cfg_shadow[BFR_REG_SYNC] + mid_id + 16'd1 + mid_res), -1);
		send_phase(30, 12);

		// payload longer than the store, so the index wraps
		push_frame(pick_id(), 16'd257, 16'($urandom), 1'b1, -1);
		settle();

		// back to reset values at full rate
		for (int k = 0; k < BFR_NUM_REGS; k++)
			write_reg(BFR_RIDX_W'(k), BFR_REG_RESET[k]);
		no_idle = 1'b1;
		send_phase(60, 12);

		$display("sent %0d bytes under %0d register settings", items_pushed, settings_used);
		$display("checked %0d payload beats and %0d frames (%0d header ok, %0d known id)",
			payload_seen, frames_seen, frames_ok, frames_known);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
